// ===== hw/rtl/ptp_pkg.sv =====
package ptp_pkg;

   // Slot bitmap geometry.
   localparam int TABLE_SLOTS = 512;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   // Effective table size runs 1..TABLE_SLOTS inclusive.
   localparam int EFF_W       = $clog2(TABLE_SLOTS + 1);

   // Fixed field widths.
   localparam int SIZE_W      = 10;
   localparam int HASH_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int KEY_BYTES   = 4;
   localparam int OUT_SLOT_W  = 9;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 48;

   localparam logic [HASH_W-1:0] FNV_PRIME        = 32'd16777619;
   localparam logic [HASH_W-1:0] RESET_BASIS      = 32'h811c9dc5;
   localparam logic [SIZE_W-1:0] RESET_TABLE_SIZE = 10'd512;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_KEY   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_LOOKUP,
      ST_UPDATE,
      ST_DONE
   } ptp_state_type;

endpackage

// ===== hw/rtl/ptp_ram.sv =====
module ptp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ptp_rem_unit.sv =====
module ptp_rem_unit
   import ptp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] dividend,
   input  logic [EFF_W-1:0]  divisor,
   output logic              done,
   output logic [EFF_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(HASH_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HASH_W-1:0] quo_ff, quo_in;
   logic [EFF_W-1:0]  rem_ff, rem_in;
   logic [EFF_W-1:0]  div_ff, div_in;

   logic [EFF_W:0]    trial;
   logic [EFF_W:0]    diff;
   logic [EFF_W-1:0]  rem_step;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {rem_ff, quo_ff[HASH_W-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_step = diff[EFF_W-1:0];
      end else begin
         rem_step = trial[EFF_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         quo_in = quo_ff << 1;
         rem_in = rem_step;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/perfect_hash_trial_placer.sv =====
// Perfect-hash trial placer.
// The req channel takes one beat per item: req_tuser selects a trial start or a key.
// A start beat loads the hash basis, clears the failure flag and sweeps the slot
// bitmap, one slot per cycle, before its all-zero result is shown.
// A key beat folds its four bytes into an FNV-1a hash, one byte per cycle through
// one constant multiplier, reduces the hash modulo the table size in a bit-serial
// remainder unit (one bit per cycle), then reads and updates the bitmap.
// req_tready is high only while the block is idle, so one item is in work at a time.
// Results sit in an output register; a stalled rsp_tready holds that beat and the
// block finishes the next item up to the point where it must hand its result over.
// After reset the bitmap is swept the same way with req_tready low;
// table size writes on the csr port are taken at any time.
module perfect_hash_trial_placer
   import ptp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [SIZE_W-1:0]     csr_wdata,    // slot count
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,    // kind
   // trial_basis, first_byte, second_byte, second_last_byte, last_byte
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hash_value, slot_index, collided, trial_failed, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [1:0] FOLD_LAST = 2'(KEY_BYTES - 1);
   localparam logic [SLOT_W-1:0] CLR_LAST = SLOT_W'(TABLE_SLOTS - 1);

   ptp_state_type state_ff, state_in;

   logic [SIZE_W-1:0] slot_count_ff, slot_count_in;
   logic [HASH_W-1:0] basis_ff, basis_in;
   logic              failed_ff, failed_in;
   logic              hit_ff, hit_in;
   logic              is_start_ff, is_start_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [1:0]        fold_ff, fold_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [EFF_W-1:0]  size_ff, size_in;
   logic [BYTE_W-1:0] key_ff [KEY_BYTES];
   logic [BYTE_W-1:0] key_in [KEY_BYTES];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              clr_last;
   logic              fold_last;
   logic              rsp_free;
   logic              rsp_load;
   logic [HASH_W-1:0] fold_x;
   logic [HASH_W-1:0] fold_prod;
   logic [EFF_W-1:0]  eff_size;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic              ram_wdata;
   logic [SLOT_W-1:0] ram_raddr;
   logic              ram_rdata;

   logic              rem_start;
   logic              rem_done;
   logic [EFF_W-1:0]  rem_value;

   assign accept    = req_tvalid && req_tready;
   assign clr_last  = (clr_ff == CLR_LAST);
   assign fold_last = (fold_ff == FOLD_LAST);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // Zero and oversize table sizes are pinned to the valid range.
   always_comb begin
      if (slot_count_ff == '0) begin
         eff_size = EFF_W'(1);
      end else if (32'(slot_count_ff) > TABLE_SLOTS) begin
         eff_size = EFF_W'(TABLE_SLOTS);
      end else begin
         eff_size = EFF_W'(slot_count_ff);
      end
   end

   assign fold_x    = hash_ff ^ {{(HASH_W - BYTE_W){1'b0}}, key_ff[fold_ff]};
   assign fold_prod = fold_x * FNV_PRIME;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = is_start_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == KIND_KEY) ? ST_HASH : ST_CLEAR;
            end
         end
         ST_HASH: begin
            if (fold_last) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (rem_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = SLOT_W'(rem_value);
      ram_wdata  = 1'b0;
      rem_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         ST_IDLE:   req_tready = 1'b1;
         ST_HASH:   rem_start  = fold_last;
         ST_UPDATE: begin
            ram_we    = !ram_rdata;
            ram_wdata = 1'b1;
         end
         ST_DONE:   rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   assign ram_raddr = SLOT_W'(rem_value);

   // Datapath.
   always_comb begin
      slot_count_in = csr_we ? csr_wdata : slot_count_ff;
      basis_in      = basis_ff;
      failed_in     = failed_ff;
      hit_in        = hit_ff;
      is_start_in   = is_start_ff;
      clr_in        = (state_ff == ST_CLEAR) ? clr_ff + SLOT_W'(1) : '0;
      fold_in       = fold_ff;
      hash_in       = hash_ff;
      size_in       = size_ff;
      key_in        = key_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         hit_in  = 1'b0;
         fold_in = '0;
         if (req_tuser == KIND_START) begin
            is_start_in = 1'b1;
            basis_in    = req_tdata[HASH_W-1:0];
            failed_in   = 1'b0;
         end else begin
            is_start_in = 1'b0;
            hash_in     = basis_ff;
            size_in     = eff_size;
            for (int i = 0; i < KEY_BYTES; i++) begin
               key_in[i] = req_tdata[HASH_W + i*BYTE_W +: BYTE_W];
            end
         end
      end

      if (state_ff == ST_HASH) begin
         hash_in = fold_prod;
         fold_in = fold_ff + 2'd1;
      end

      if (state_ff == ST_UPDATE && ram_rdata) begin
         hit_in    = 1'b1;
         failed_in = 1'b1;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (is_start_ff) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in = RSP_DATA_W'({failed_ff, hit_ff,
                                       OUT_SLOT_W'(rem_value), hash_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         slot_count_ff <= RESET_TABLE_SIZE;
         basis_ff      <= RESET_BASIS;
         failed_ff     <= 1'b0;
         is_start_ff   <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         basis_ff      <= basis_in;
         failed_ff     <= failed_in;
         is_start_ff   <= is_start_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hit_ff      <= hit_in;
      fold_ff     <= fold_in;
      hash_ff     <= hash_in;
      size_ff     <= size_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   ptp_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ptp_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (fold_prod),
      .divisor   (size_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A collision always leaves the sticky flag set in the same beat.
   a_collide_sets_failed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[HASH_W + OUT_SLOT_W] || rsp_tdata[HASH_W + OUT_SLOT_W + 1]))
      else $error("collided beat without trial_failed");

   // The bitmap is only touched by the sweep or a key update.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !ram_we)
      else $error("bitmap written while idle");

   a_rem_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> (state_ff == ST_MOD))
      else $error("remainder finished outside the modulo state");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> (rem_value < size_ff))
      else $error("remainder not below table size");

endmodule

// ===== dv/perfect_hash_trial_placer_tb.sv =====
module perfect_hash_trial_placer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptp_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_BEATS   = 45;

   typedef struct packed {
      logic [HASH_W-1:0]     hash_value;
      logic [OUT_SLOT_W-1:0] slot_index;
      logic                  collided;
      logic                  trial_failed;
   } placement_type;

   typedef struct {
      logic                  kind;
      logic [REQ_DATA_W-1:0] data;
      bit                    drain_after;
   } req_beat_type;

   // Tracks the slot bitmap, basis and failure flag, and queues the result that
   // each accepted request beat must produce.
   class placement_scoreboard;
      bit                slot_taken [TABLE_SLOTS];
      logic [HASH_W-1:0] trial_basis;
      bit                trial_failed;
      logic [SIZE_W-1:0] slot_count;
      placement_type     expected_q[$];
      int unsigned       error_count;

      function new();
         trial_basis  = RESET_BASIS;
         trial_failed = 1'b0;
         slot_count   = RESET_TABLE_SIZE;
         error_count  = 0;
      endfunction

      function void set_slot_count(logic [SIZE_W-1:0] value);
         slot_count = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_beat(logic kind, logic [REQ_DATA_W-1:0] data);
         placement_type want;
         bit [31:0]     h;
         int unsigned   slots;
         int unsigned   slot;
         want = '0;
         if (kind == KIND_START) begin
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            trial_basis  = data[HASH_W-1:0];
            trial_failed = 1'b0;
         end else begin
            h = trial_basis;
            for (int b = 0; b < KEY_BYTES; b++) begin
               h = (h ^ {24'd0, data[HASH_W + BYTE_W*b +: BYTE_W]}) * FNV_PRIME;
            end
            // A zero size behaves as one slot; anything above the bitmap saturates.
            slots = (slot_count == 0) ? 1 : slot_count;
            if (slots > TABLE_SLOTS) slots = TABLE_SLOTS;
            slot = h % slots;
            if (slot_taken[slot]) begin
               want.collided = 1'b1;
               trial_failed  = 1'b1;
            end else begin
               slot_taken[slot] = 1'b1;
            end
            want.hash_value = h;
            want.slot_index = slot[OUT_SLOT_W-1:0];
         end
         want.trial_failed = trial_failed;
         expected_q.push_back(want);
      endfunction

      function void check_beat(logic [RSP_DATA_W-1:0] data);
         placement_type got;
         placement_type want;
         got.hash_value   = data[31:0];
         got.slot_index   = data[40:32];
         got.collided     = data[41];
         got.trial_failed = data[42];
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: %h", data);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         if (got.hash_value !== want.hash_value) begin
            $error("hash_value: expected %h, actual %h", want.hash_value, got.hash_value);
            error_count++;
         end
         if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
            error_count++;
         end
         if (got.collided !== want.collided) begin
            $error("collided: expected %b, actual %b", want.collided, got.collided);
            error_count++;
         end
         if (got.trial_failed !== want.trial_failed) begin
            $error("trial_failed: expected %b, actual %b", want.trial_failed,
                   got.trial_failed);
            error_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [SIZE_W-1:0]     csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = KIND_START;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   placement_scoreboard placements = new();
   req_beat_type        run_q[$];
   int unsigned         burst_left = 1;
   int unsigned         cycle_count = 0;

   perfect_hash_trial_placer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: the stall behavior switches at random between always
   // ready, coin-flip ready and mostly stalled.
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) placements.check_beat(rsp_tdata);
   end

   function automatic void add_beat(logic kind, logic [31:0] basis, logic [31:0] key,
                                    bit drain_after);
      req_beat_type b;
      b.kind        = kind;
      b.data        = {key, basis};   // first_byte sits in key[7:0]
      b.drain_after = drain_after;
      run_q.push_back(b);
   endfunction

   function automatic logic [31:0] pick_basis();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // One trial: usually a start followed by keys, sometimes a missing or doubled
   // start, and now and then a key repeated to force a collision.
   function automatic void add_trial(int unsigned key_count);
      logic [31:0] keys[$];
      logic [31:0] key;
      int unsigned shape;
      shape = $urandom_range(0, 9);
      if (shape != 0) add_beat(KIND_START, pick_basis(), $urandom, 1'b0);
      if (shape == 1) add_beat(KIND_START, pick_basis(), $urandom, 1'b0);
      for (int unsigned i = 0; i < key_count; i++) begin
         if (keys.size() != 0 && $urandom_range(0, 7) == 0) begin
            key = keys[$urandom_range(0, keys.size() - 1)];
         end else begin
            key = $urandom;
         end
         keys.push_back(key);
         add_beat(KIND_KEY, $urandom, key, (i + 1 == key_count) && $urandom_range(0, 5) == 0);
      end
   endfunction

   task automatic send_beat(req_beat_type b, bit more);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= b.kind;
      req_tdata  <= b.data;
      do @(posedge clock); while (!req_tready);
      placements.note_beat(b.kind, b.data);
      gap = 0;
      if (burst_left <= 1) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 25);
      end else begin
         burst_left--;
      end
      if (!more || gap != 0 || b.drain_after) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (b.drain_after) begin
         while (placements.pending() != 0) @(posedge clock);
      end
   endtask

   task automatic send_run();
      for (int i = 0; i < run_q.size(); i++) begin
         send_beat(run_q[i], i + 1 < run_q.size());
      end
      run_q.delete();
   endtask

   task automatic drain();
      while (placements.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_count(logic [SIZE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      placements.set_slot_count(value);
   endtask

   initial begin
      int unsigned phase_sizes[12];
      int unsigned key_count;
      phase_sizes = '{1, 2, 0, 13, 100, 256, 511, 512, 1023, 700, 0, 0};
      phase_sizes[10] = $urandom_range(0, 1023);
      phase_sizes[11] = $urandom_range(1, 64);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Keys ahead of any start use the reset basis and an empty bitmap.
      add_beat(KIND_KEY, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_beat(KIND_KEY, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
      add_beat(KIND_KEY, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_beat(KIND_KEY, $urandom, 32'h1234_5678, 1'b0);
      add_beat(KIND_START, 32'h0000_0000, 32'hffff_ffff, 1'b0);
      add_beat(KIND_KEY, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_beat(KIND_KEY, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
      add_beat(KIND_START, 32'hffff_ffff, 32'h0000_0000, 1'b0);
      add_beat(KIND_KEY, $urandom, 32'ha55a_3cc3, 1'b0);
      add_beat(KIND_KEY, $urandom, 32'ha55a_3cc3, 1'b0);
      send_run();
      drain();

      // With a zero size every key lands in slot zero.
      write_slot_count('0);
      add_beat(KIND_START, $urandom, $urandom, 1'b0);
      add_beat(KIND_KEY, $urandom, $urandom, 1'b0);
      add_beat(KIND_KEY, $urandom, $urandom, 1'b0);
      add_beat(KIND_KEY, $urandom, 32'h0000_0000, 1'b0);
      send_run();
      drain();

      write_slot_count(10'h3ff);
      add_beat(KIND_START, RESET_BASIS, $urandom, 1'b0);
      add_beat(KIND_KEY, $urandom, 32'h6463_6261, 1'b0);
      add_beat(KIND_KEY, $urandom, $urandom, 1'b0);
      send_run();
      drain();

      foreach (phase_sizes[p]) begin
         write_slot_count(phase_sizes[p][SIZE_W-1:0]);
         while (run_q.size() < PHASE_BEATS) begin
            key_count = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 20);
            add_trial(key_count);
         end
         send_run();
         drain();
      end

      if (placements.error_count == 0 && placements.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
